[rtl/core/tru_pkg.sv]
// tru_pkg: shared constants and the row word type for the triangular row unpacker.
// Used by tru_front, tru_engine and triangular_row_unpacker. No dependencies.
`default_nettype none

package tru_pkg;

	localparam int MaxVarsDefault = 512;
	localparam int WordBits = 64;
	localparam int RowNumBits = 10;
	localparam logic [RowNumBits-1:0] NumVarsReset = 10'd512;
	localparam int FifoDepth = 2;

	typedef struct packed {
		logic [RowNumBits-1:0] row_number;
		logic                  constant_bit;
		logic                  equation_last;
		logic                  row_last;
		logic [WordBits-1:0]   word;
	} row_word_t;

endpackage

`default_nettype wire

[rtl/core/tru_front.sv]
// tru_front: input side of the unpacker, a short word queue ahead of the engine.
// Depends on tru_pkg for the word width and queue depth.
`default_nettype none

module tru_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_valid,
	output logic                              s_ready,
	input  wire logic [tru_pkg::WordBits-1:0] s_word,
	output logic                              q_valid,
	input  wire logic                         q_ready,
	output logic [tru_pkg::WordBits-1:0]      q_word
);

	localparam int Depth = tru_pkg::FifoDepth;
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [tru_pkg::WordBits-1:0] mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;
	logic pop;

	assign s_ready = (count_q != CntW'(Depth));
	assign q_valid = (count_q != '0);
	assign q_word  = mem_q[rd_ptr_q];
	assign push    = s_valid && s_ready;
	assign pop     = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= s_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= CntW'(count_q + 1'b1);
				2'b01:   count_q <= CntW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/tru_engine.sv]
// tru_engine: bit buffer, row tracking and output register of the unpacker.
// Depends on tru_pkg for the row word type and widths.
`default_nettype none

module tru_engine #(
	parameter int MAX_VARS = tru_pkg::MaxVarsDefault
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [tru_pkg::RowNumBits-1:0] num_vars,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tru_pkg::WordBits-1:0]   in_word,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output tru_pkg::row_word_t                  out_data
);

	localparam int RowW = $clog2(MAX_VARS + 1);
	localparam int RowWords = (MAX_VARS + 63) / 64;
	localparam int WirW = (RowWords > 1) ? $clog2(RowWords) : 1;
	localparam int RemW = (RowW > WirW + 6) ? RowW : WirW + 6;

	logic [127:0]       buf_q;
	logic [6:0]         cnt_q;
	logic [RowW-1:0]    row_q;
	logic [WirW-1:0]    wir_q;
	logic               const_q;
	logic               expect_q;
	logic               out_valid_q;
	tru_pkg::row_word_t out_q;

	logic [RowW-1:0] nv_eff;
	logic [RemW-1:0] rem;
	logic [6:0]      need;
	logic            row_end;
	logic            eq_end;
	logic            slot_free;
	logic            emit;
	logic            load;
	logic [63:0]     mask;
	logic [63:0]     word;

	always_comb begin
		priority if (num_vars == '0) begin
			nv_eff = RowW'(1);
		end else if (int'(num_vars) > MAX_VARS) begin
			nv_eff = RowW'(MAX_VARS);
		end else begin
			nv_eff = RowW'(num_vars);
		end
	end

	assign rem       = RemW'(row_q) - RemW'({wir_q, 6'd0});
	assign row_end   = (rem <= RemW'(64));
	assign need      = row_end ? rem[6:0] : 7'd64;
	assign eq_end    = row_end && (row_q >= nv_eff);
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = !expect_q && (cnt_q >= need) && slot_free;
	assign in_ready  = expect_q || (cnt_q < need);
	assign load      = in_valid && in_ready;
	assign mask      = (need == 7'd64) ? {64{1'b1}} : ~({64{1'b1}} << need[5:0]);
	assign word      = buf_q[63:0] & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q    <= '0;
			cnt_q    <= '0;
			row_q    <= RowW'(1);
			wir_q    <= '0;
			const_q  <= 1'b0;
			expect_q <= 1'b1;
		end else begin
			priority if (load && expect_q) begin
				buf_q    <= {65'd0, in_word[63:1]};
				cnt_q    <= 7'd63;
				const_q  <= in_word[0];
				row_q    <= RowW'(1);
				wir_q    <= '0;
				expect_q <= 1'b0;
			end else if (load) begin
				buf_q <= buf_q | ({64'd0, in_word} << cnt_q[5:0]);
				cnt_q <= cnt_q + 7'd64;
			end else if (emit) begin
				if (eq_end) begin
					// rest of the word is padding
					buf_q    <= '0;
					cnt_q    <= '0;
					row_q    <= RowW'(1);
					wir_q    <= '0;
					expect_q <= 1'b1;
				end else begin
					buf_q <= buf_q >> need;
					cnt_q <= cnt_q - need;
					if (row_end) begin
						row_q <= RowW'(row_q + 1'b1);
						wir_q <= '0;
					end else begin
						wir_q <= WirW'(wir_q + 1'b1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.word          <= word;
			out_q.row_last      <= row_end;
			out_q.equation_last <= eq_end;
			out_q.constant_bit  <= const_q;
			out_q.row_number    <= tru_pkg::RowNumBits'(row_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_fresh_state: assert property (@(posedge clk) disable iff (!arst_n)
		expect_q |-> (cnt_q == 7'd0 && wir_q == '0 && row_q == RowW'(1)))
		else $error("bit buffer not clear while waiting for a new equation");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !expect_q) |-> (cnt_q < 7'd64))
		else $error("bit buffer would overflow on word merge");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && need != 7'd64) |=> ((out_q.word >> $past(need)) == 64'd0))
		else $error("row tail word not zero padded");

	a_eq_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && eq_end) |=> (expect_q && out_valid_q && out_q.row_last))
		else $error("equation end did not restart the unpacker");

endmodule

`default_nettype wire

[rtl/core/triangular_row_unpacker.sv]
// triangular_row_unpacker: top level, row count register, input queue and engine.
// Depends on tru_pkg, tru_front and tru_engine.
`default_nettype none

// Unpacks one GF(2) quadratic equation per run of 64-bit input words: stream bit 0
// is the constant, then rows 1..num_vars of a lower-triangular matrix, each
// emitted as 64-bit words with zero padding at the row end. Each input word is
// merged into the 128-bit bit buffer, and each output word is shifted out
// through the same buffer shifter; the engine takes no new input word while
// the buffer holds enough bits for the next output word. A two-word input
// queue and an output register let both sides stall freely.
// Bits after the last row of an equation are dropped and the next word starts
// a new equation. num_vars of 0 acts as 1 and values above MAX_VARS as MAX_VARS.
module triangular_row_unpacker #(
	parameter int MAX_VARS = tru_pkg::MaxVarsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [9:0]  cfg_wdata,     // num_vars
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [63:0] in_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,  // [63:0] out_word, [64] constant_bit,
	                                        // [74:65] row_number, [79:75] zero
	output logic             m_axis_tuser,  // [0] row_last
	output logic             m_axis_tlast   // equation_last
);

	logic [tru_pkg::RowNumBits-1:0] num_vars_q;
	logic                           q_valid;
	logic                           q_ready;
	logic [tru_pkg::WordBits-1:0]   q_word;
	tru_pkg::row_word_t             out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= tru_pkg::NumVarsReset;
		end else if (cfg_wen) begin
			num_vars_q <= cfg_wdata;
		end
	end

	tru_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_word  (s_axis_tdata),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_word  (q_word)
	);

	tru_engine #(
		.MAX_VARS (MAX_VARS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_vars  (num_vars_q),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_word   (q_word),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign m_axis_tdata = {5'd0, out_data.row_number, out_data.constant_bit, out_data.word};
	assign m_axis_tuser = out_data.row_last;
	assign m_axis_tlast = out_data.equation_last;

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for triangular_row_unpacker: random and directed 64-bit stream words,
// row count changes between phases, with results predicted in a small scoreboard class.
// Depends on tru_pkg and the triangular_row_unpacker RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int StallLimit = 5000;
	localparam int MaxWordsPerInput = 11;

	class unpack_scoreboard;
		logic [9:0]  rows_reg;
		logic [127:0] stream_bits;
		int          stream_count;
		int          cur_row;
		int          word_idx;
		bit          eq_constant;
		bit          at_eq_start;
		int          errors;
		tru_pkg::row_word_t row_words_due[$];

		function new();
			rows_reg = tru_pkg::NumVarsReset;
			stream_bits = '0;
			stream_count = 0;
			cur_row = 1;
			word_idx = 0;
			eq_constant = 1'b0;
			at_eq_start = 1'b1;
			errors = 0;
		endfunction

		function void set_rows(logic [9:0] value);
			rows_reg = value;
		endfunction

		function int pending();
			return row_words_due.size();
		endfunction

		// Merge one stream word and release every row word it completes.
		function void absorb_word(logic [63:0] w);
			int nv;
			int low;
			int span;
			int rem;
			int need;
			int made;
			logic [63:0] word;
			bit row_end;
			bit eq_end;
			tru_pkg::row_word_t rw;
			nv = rows_reg;
			if (nv < 1) nv = 1;
			if (nv > tru_pkg::MaxVarsDefault) nv = tru_pkg::MaxVarsDefault;
			made = 0;
			if (at_eq_start) begin
				eq_constant = w[0];
				stream_bits = {65'b0, w[63:1]};
				stream_count = 63;
				cur_row = 1;
				word_idx = 0;
				at_eq_start = 1'b0;
			end else begin
				low = stream_count % 64;
				if (low == 0)
					stream_bits = {64'b0, w};
				else
					stream_bits = {64'b0, stream_bits[63:0]} | ({64'b0, w} << low);
				stream_count = low + 64;
			end
			while (made < MaxWordsPerInput) begin
				span = word_idx * 64;
				rem = (cur_row > span) ? cur_row - span : 1;
				need = (rem < 64) ? rem : 64;
				if (stream_count < need)
					break;
				word = stream_bits[63:0];
				if (need < 64)
					word = word & ((64'd1 << need) - 64'd1);
				stream_bits = stream_bits >> need;
				stream_count = stream_count - need;
				row_end = (rem <= 64);
				eq_end = row_end && (cur_row >= nv);
				rw.word = word;
				rw.row_last = row_end;
				rw.equation_last = eq_end;
				rw.constant_bit = eq_constant;
				rw.row_number = cur_row[9:0];
				row_words_due.push_back(rw);
				made++;
				if (eq_end) begin
					stream_bits = '0;
					stream_count = 0;
					cur_row = 1;
					word_idx = 0;
					at_eq_start = 1'b1;
					break;
				end
				if (row_end) begin
					cur_row++;
					word_idx = 0;
				end else begin
					word_idx++;
				end
			end
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			$display("%0t mismatch %s: expected %h actual %h", $time, field, want, got);
			errors++;
		endfunction

		function void check_row_word(logic [79:0] data, logic user, logic last);
			tru_pkg::row_word_t want;
			if (row_words_due.size() == 0) begin
				$display("%0t unexpected word: expected none actual %h", $time, data);
				errors++;
				return;
			end
			want = row_words_due.pop_front();
			if (data[63:0] !== want.word)
				report("out_word", want.word, data[63:0]);
			if (data[64] !== want.constant_bit)
				report("constant_bit", want.constant_bit, data[64]);
			if (data[74:65] !== want.row_number)
				report("row_number", want.row_number, data[74:65]);
			if (user !== want.row_last)
				report("row_last", want.row_last, user);
			if (last !== want.equation_last)
				report("equation_last", want.equation_last, last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [9:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	unpack_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	triangular_row_unpacker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 300;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_row_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready)
				sb.absorb_word(s_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_wen)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("%0t watchdog: no word moved for %0d cycles", $time, StallLimit);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [63:0] w);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_rows(input logic [9:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_rows(value);
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_word({$urandom, $urandom});
	endtask

	task automatic run_rows(input logic [9:0] value, input int count);
		drain();
		write_rows(value);
		send_random(count);
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	logic [63:0] edge_words [14] = '{
		64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h8000_0000_0000_0000,
		64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h0123_4567_89AB_CDEF,
		64'hFEDC_BA98_7654_3210, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
		64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0F0F_0F0F_0F0F_0F0F,
		64'hF0F0_F0F0_F0F0_F0F0
	};

	initial begin
		sb = new();
		set_idling(27, 79);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset row count, then cut the equation short by shrinking the count
		foreach (edge_words[i])
			send_word(edge_words[i]);
		drain();
		write_rows(10'd1);
		send_word(64'h0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF);
		send_word(64'h1);
		send_word(64'h2);

		run_rows(10'd0, 12);
		run_rows(10'd3, 16);
		run_rows(10'd11, 12);
		run_rows(10'd64, 34);

		set_idling(79, 27);
		run_rows(10'd2, 8);
		run_rows(10'd65, 12);
		drain();
		send_random(6);
		run_rows(10'd12, 8);
		run_rows(10'($urandom_range(4, 40)), 8);

		set_idling(0, 0);
		drain();
		write_rows(10'd1023);
		hold_req = 1'b1;
		send_random(12);
		run_rows(10'd90, 8);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
